// ===== sv/shsar_pkg.sv =====
// Shared constants, types and phase table for the half-step auto-reverse stepper driver.
`timescale 1ns / 1ps

package shsar_pkg;

    localparam int unsigned SPEED_W       = 2;
    localparam int unsigned COIL_W        = 4;
    localparam int unsigned HALF_PERIOD_W = 12;
    localparam int unsigned TICK_W        = HALF_PERIOD_W + 1;
    localparam int unsigned SPEED_CNT_W   = 3;
    localparam int unsigned STEP_W        = 3;
    localparam int unsigned APB_ADDR_W    = 3;
    localparam int unsigned APB_DATA_W    = 32;

    localparam logic [HALF_PERIOD_W-1:0] HALF_PERIOD_RST = HALF_PERIOD_W'(400);

    // Register index, taken from the word address bit
    localparam logic REG_HALF_PERIOD = 1'b0;

    typedef logic [SPEED_W-1:0]       t_speed_sel;
    typedef logic [COIL_W-1:0]        t_coil;
    typedef logic [HALF_PERIOD_W-1:0] t_half_period;
    typedef logic [TICK_W-1:0]        t_ticks;
    typedef logic [SPEED_CNT_W-1:0]   t_speed_cnt;
    typedef logic [STEP_W-1:0]        t_step;

    // Half-step coil sequence
    function automatic t_coil phase_lookup(input t_step idx);
        t_coil v;
        case (idx)
            3'd0:    v = 4'h1;
            3'd1:    v = 4'h3;
            3'd2:    v = 4'h2;
            3'd3:    v = 4'h6;
            3'd4:    v = 4'h4;
            3'd5:    v = 4'hC;
            3'd6:    v = 4'h8;
            3'd7:    v = 4'h9;
            default: v = 4'h1;
        endcase
        return v;
    endfunction

endpackage

// ===== sv/shsar_in_if.sv =====
// Tick input channel: valid/ready handshake carrying the speed select.
`timescale 1ns / 1ps

interface shsar_in_if;
    logic                    valid;
    logic                    ready;
    shsar_pkg::t_speed_sel   speed_sel;

    modport source (output valid, output speed_sel, input ready);
    modport sink   (input valid, input speed_sel, output ready);
endinterface

// ===== sv/shsar_out_if.sv =====
// Drive output channel: valid/ready handshake carrying coil pattern and direction.
`timescale 1ns / 1ps

interface shsar_out_if;
    logic               valid;
    logic               ready;
    shsar_pkg::t_coil   coil_pattern;
    logic               clockwise;

    modport source (output valid, output coil_pattern, output clockwise, input ready);
    modport sink   (input valid, input coil_pattern, input clockwise, output ready);
endinterface

// ===== sv/shsar_apb_regs.sv =====
// APB configuration register holding the half period.
`timescale 1ns / 1ps

module shsar_apb_regs (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [shsar_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [shsar_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [shsar_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                 pready,
    output shsar_pkg::t_half_period              o_half_period
);

    shsar_pkg::t_half_period r_half_period;
    shsar_pkg::t_half_period n_half_period;
    logic                    w_sel_hp;

    assign w_sel_hp = (paddr[2] == shsar_pkg::REG_HALF_PERIOD);

    always_comb begin
        n_half_period = r_half_period;
        if (psel && penable && pwrite && pready && w_sel_hp) begin
            n_half_period = pwdata[shsar_pkg::HALF_PERIOD_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_period <= shsar_pkg::HALF_PERIOD_RST;
        end else begin
            r_half_period <= n_half_period;
        end
    end

    assign pready        = 1'b1;
    assign prdata        = w_sel_hp ? shsar_pkg::APB_DATA_W'(r_half_period) : '0;
    assign o_half_period = r_half_period;

endmodule

// ===== sv/shsar_core.sv =====
// Tick register, direction and step update, and result register.
`timescale 1ns / 1ps

module shsar_core (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  shsar_pkg::t_half_period  i_half_period,
    shsar_in_if.sink                 i_tick,
    shsar_out_if.source              o_drive
);

    logic                   r_in_valid;
    shsar_pkg::t_speed_sel  r_speed_sel;
    logic                   r_out_valid;
    shsar_pkg::t_coil       r_coil;
    logic                   r_clockwise;
    shsar_pkg::t_ticks      r_elapsed;
    shsar_pkg::t_speed_cnt  r_speed_count;
    shsar_pkg::t_step       r_step_index;

    logic                   n_in_valid;
    logic                   n_out_valid;
    shsar_pkg::t_ticks      n_elapsed;
    shsar_pkg::t_speed_cnt  n_speed_count;
    shsar_pkg::t_step       n_step_index;
    logic                   n_clockwise;

    logic                   w_advance;
    logic                   w_in_ready;
    shsar_pkg::t_ticks      w_elapsed_inc;
    shsar_pkg::t_ticks      w_hp;
    shsar_pkg::t_ticks      w_hp2;
    shsar_pkg::t_speed_cnt  w_speed_inc;
    shsar_pkg::t_speed_cnt  w_threshold;

    // Result register frees up when empty or being taken
    assign w_advance  = r_in_valid && (!r_out_valid || o_drive.ready);
    assign w_in_ready = !r_in_valid || w_advance;

    always_comb begin
        w_elapsed_inc = r_elapsed + 1'b1;
        w_hp          = {1'b0, i_half_period};
        w_hp2         = {i_half_period, 1'b0};
        if (w_elapsed_inc <= w_hp) begin
            n_clockwise = 1'b1;
            n_elapsed   = w_elapsed_inc;
        end else if (w_elapsed_inc <= w_hp2) begin
            n_clockwise = 1'b0;
            n_elapsed   = w_elapsed_inc;
        end else begin
            // past both halves: wrap and restart clockwise
            n_clockwise = 1'b1;
            n_elapsed   = '0;
        end

        w_speed_inc = r_speed_count + 1'b1;
        w_threshold = {1'b0, r_speed_sel} + 1'b1;
        if (w_speed_inc >= w_threshold) begin
            n_speed_count = '0;
            n_step_index  = n_clockwise ? r_step_index + 1'b1 : r_step_index - 1'b1;
        end else begin
            n_speed_count = w_speed_inc;
            n_step_index  = r_step_index;
        end
    end

    always_comb begin
        n_in_valid = r_in_valid;
        if (i_tick.valid && w_in_ready) begin
            n_in_valid = 1'b1;
        end else if (w_advance) begin
            n_in_valid = 1'b0;
        end
        n_out_valid = r_out_valid;
        if (w_advance) begin
            n_out_valid = 1'b1;
        end else if (o_drive.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_elapsed     <= '0;
            r_speed_count <= '0;
            r_step_index  <= '0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
            if (w_advance) begin
                r_elapsed     <= n_elapsed;
                r_speed_count <= n_speed_count;
                r_step_index  <= n_step_index;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_tick.valid && w_in_ready) begin
            r_speed_sel <= i_tick.speed_sel;
        end
        if (w_advance) begin
            r_coil      <= shsar_pkg::phase_lookup(n_step_index);
            r_clockwise <= n_clockwise;
        end
    end

    assign i_tick.ready         = w_in_ready;
    assign o_drive.valid        = r_out_valid;
    assign o_drive.coil_pattern = r_coil;
    assign o_drive.clockwise    = r_clockwise;

    a_speed_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_speed_count <= 3'd3)
        else $error("speed counter beyond largest threshold");

    a_coil_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ($countones(r_coil) == 1 || $countones(r_coil) == 2))
        else $error("coil pattern is not a half-step phase");

    a_ccw_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_clockwise) |-> (r_elapsed != '0))
        else $error("counter-clockwise beat with wrapped tick counter");

    a_advance_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance |=> r_out_valid)
        else $error("processed tick did not reach result register");

    a_step_moves_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance |=> (r_step_index == $past(r_step_index)
                       || r_step_index == $past(r_step_index) + 3'd1
                       || r_step_index == $past(r_step_index) - 3'd1))
        else $error("step index jumped more than one place");

endmodule

// ===== sv/stepper_half_step_auto_reverse.sv =====
// Top level of the half-step stepper driver with automatic direction reversal.
//
// Usage:
//   i_tick carries one timer tick per beat with its speed select; o_drive
//   returns one beat per tick with the four coil drive bits and the direction.
//   The direction is clockwise for the first half_period ticks, then
//   counter-clockwise for as many, then a clockwise tick wraps the count and the pattern repeats.
//   The phase index advances once every speed_sel+1 ticks.
//   half_period is written through the APB port at byte address 0 (reset 400);
//   write it only while no tick is in flight.
// Timing:
//   A tick taken at one clock edge is registered in the input register,
//   processed by the counter and table logic and written to the result
//   register, which drives o_drive. One tick is accepted every cycle while
//   o_drive is not held; the rate is set by the single register-to-register
//   update of the tick, speed and phase counters.
// Reset: synchronous, active low; clears counters and both pipeline stages.
// Stall: while o_drive is held, the result stays put, one further tick is
//   held in the input register, then i_tick.ready drops.
`timescale 1ns / 1ps

module stepper_half_step_auto_reverse (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [shsar_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [shsar_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [shsar_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                 pready,
    shsar_in_if.sink                             i_tick,
    shsar_out_if.source                          o_drive
);

    shsar_pkg::t_half_period w_half_period;

    shsar_apb_regs u_regs (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .o_half_period (w_half_period)
    );

    shsar_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_half_period (w_half_period),
        .i_tick        (i_tick),
        .o_drive       (o_drive)
    );

endmodule
